FILE: src/radar_target_tally_table_top_defines.svh
// Assertion macros for the radar target tally table checker
`ifndef RADAR_TARGET_TALLY_TABLE_TOP_DEFINES_SVH
`define RADAR_TARGET_TALLY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define RTTT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rttt check failed");

// Next-cycle implication, sampled on clock, off during reset
`define RTTT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rttt check failed");

`endif

FILE: src/rttt_pkg.sv
// Shared types, codes and constants of the radar target tally table
package rttt_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   localparam logic [1:0] CMD_FRAME  = 2'd0;
   localparam logic [1:0] CMD_TARGET = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [2:0] ST_IGNORED  = 3'd0;
   localparam logic [2:0] ST_FILTERED = 3'd1;
   localparam logic [2:0] ST_MATCHED  = 3'd2;
   localparam logic [2:0] ST_INSERTED = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_FRAME    = 3'd5;
   localparam logic [2:0] ST_CLEARED  = 3'd6;

   localparam logic [2:0] REG_FILTER_CONTROL = 3'd0;
   localparam logic [2:0] REG_REF_DISTANCE   = 3'd1;
   localparam logic [2:0] REG_REF_AZIMUTH    = 3'd2;
   localparam logic [2:0] REG_REF_ELEVATION  = 3'd3;
   localparam logic [2:0] REG_REF_SPEED      = 3'd4;
   localparam logic [2:0] REG_REF_RCS        = 3'd5;
   localparam logic [2:0] REG_REF_SNR        = 3'd6;
   localparam logic [2:0] REG_REF_MAGNITUDE  = 3'd7;

   localparam logic [16:0] WIN_RANGE = 17'd200;
   localparam logic [16:0] WIN_ANGLE = 17'd500;
   localparam logic [16:0] WIN_SPEED = 17'd200;
   localparam logic [16:0] WIN_DB    = 17'd50;
   localparam logic [16:0] TOL_POS   = 17'd5;
   localparam logic [16:0] TOL_MAG   = 17'd30;

   localparam logic [13:0] PERMYRIAD = 14'd10000;
   localparam logic [3:0]  DIV_STEPS_M1 = 4'd13;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         profile_code;
      logic [15:0]        object_count;
      logic signed [15:0] speed;
      logic signed [15:0] azimuth;
      logic [31:0]        distance;
      logic [15:0]        magnitude;
      logic signed [15:0] rcs;
      logic signed [15:0] snr;
      logic signed [15:0] elevation;
   } rttt_item_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic search;
      logic update;
      logic mul;
      logic div_step;
      logic out_load;
   } rttt_cmd_type;

   typedef struct packed {
      logic go;
      logic found;
      logic miss;
      logic div_last;
   } rttt_stat_type;

   function automatic logic [16:0] absdiff17(logic signed [16:0] a, logic signed [16:0] b);
      logic signed [17:0] d;
      d = 18'(a) - 18'(b);
      return (d < 0) ? 17'(-d) : 17'(d);
   endfunction

   function automatic logic [31:0] absdiff32(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] d;
      d = $signed({1'b0, a}) - $signed({1'b0, b});
      return (d < 0) ? 32'(-d) : 32'(d);
   endfunction

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

FILE: src/rttt_if.sv
// Handshake channel interfaces for request, response and register writes
interface rttt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [7:0]         profile_code;
   logic [15:0]        object_count;
   logic signed [15:0] speed;
   logic signed [15:0] azimuth;
   logic [31:0]        distance;
   logic [15:0]        magnitude;
   logic signed [15:0] rcs;
   logic signed [15:0] snr;
   logic signed [15:0] elevation;
   modport source (output valid, command, profile_code, object_count, speed, azimuth,
                   distance, magnitude, rcs, snr, elevation, input ready);
   modport sink (input valid, command, profile_code, object_count, speed, azimuth,
                 distance, magnitude, rcs, snr, elevation, output ready);
endinterface

interface rttt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [5:0]  entry_index;
   logic [31:0] hit_count;
   logic [13:0] live_permyriad;
   logic [31:0] frame_total;
   modport source (output valid, status, entry_index, hit_count, live_permyriad,
                   frame_total, input ready);
   modport sink (input valid, status, entry_index, hit_count, live_permyriad,
                 frame_total, output ready);
endinterface

interface rttt_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/rttt_ctrl.sv
// Controller state machine sequencing decode, table search, update and ratio division
module rttt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rttt_pkg::rttt_stat_type stat,
   output rttt_pkg::rttt_cmd_type  cmd
);
   import rttt_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_MUL    = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_RESULT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.go ? S_SEARCH : S_RESULT;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (stat.found || stat.miss) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: src/rttt_dp.sv
// Datapath: registers, counters, entry table memory, matcher and ratio divider
module rttt_dp #(
   parameter int TABLE_DEPTH = rttt_pkg::TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rttt_pkg::rttt_item_type item,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_data,
   input  rttt_pkg::rttt_cmd_type  cmd,
   output rttt_pkg::rttt_stat_type stat,
   output logic [2:0]             rsp_status,
   output logic [5:0]             rsp_entry_index,
   output logic [31:0]            rsp_hit_count,
   output logic [13:0]            rsp_live_permyriad,
   output logic [31:0]            rsp_frame_total
);
   import rttt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [7:0]         fctl_ff;
   logic [31:0]        rdist_ff;
   logic signed [15:0] razi_ff, rele_ff, rspd_ff, rrcs_ff, rsnr_ff;
   logic [15:0]        rmag_ff;

   rttt_item_type item_ff;
   logic [7:0]    fprof_ff, fprof_in;
   logic [31:0]   fc_ff, fc_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          pv_ff, pv_in;
   logic [AW-1:0] pidx_ff, pidx_in;
   logic          found_ff, found_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [31:0]   hits_ff, hits_in;
   logic [2:0]    st_ff, st_in;
   logic [45:0]   prod_ff, prod_in;
   logic [45:0]   dsh_ff, dsh_in;
   logic [13:0]   q_ff, q_in;
   logic [3:0]    step_ff, step_in;
   logic          sat_ff, sat_in;

   logic [7:0]  prof_mem [TABLE_DEPTH];
   logic [31:0] dist_mem [TABLE_DEPTH];
   logic [31:0] ang_mem  [TABLE_DEPTH];
   logic [31:0] sm_mem   [TABLE_DEPTH];
   logic [31:0] rs_mem   [TABLE_DEPTH];
   logic [31:0] hits_mem [TABLE_DEPTH];
   logic [7:0]  rd_prof_ff;
   logic [31:0] rd_dist_ff, rd_ang_ff, rd_sm_ff, rd_hits_ff;

   logic          rd_en, wr_all, wr_hit;
   logic [AW-1:0] wr_addr;
   logic          reject, hit, ratio;
   logic [31:0]   rs_word;

   assign rs_word = {item_ff.rcs, item_ff.snr};

   assign reject =
      (fctl_ff[0] && (absdiff32(rdist_ff, item_ff.distance) > 32'(WIN_RANGE))) ||
      (fctl_ff[1] && (absdiff17({razi_ff[15], razi_ff}, {item_ff.azimuth[15], item_ff.azimuth})
                      > WIN_ANGLE)) ||
      (fctl_ff[2] && (absdiff17({rele_ff[15], rele_ff},
                      {item_ff.elevation[15], item_ff.elevation}) > WIN_ANGLE)) ||
      (fctl_ff[3] && (absdiff17({rspd_ff[15], rspd_ff}, {item_ff.speed[15], item_ff.speed})
                      > WIN_SPEED)) ||
      (fctl_ff[4] && (absdiff17({rrcs_ff[15], rrcs_ff}, {item_ff.rcs[15], item_ff.rcs})
                      > WIN_DB)) ||
      (fctl_ff[5] && (absdiff17({rsnr_ff[15], rsnr_ff}, {item_ff.snr[15], item_ff.snr})
                      > WIN_DB)) ||
      (fctl_ff[6] && (absdiff17({1'b0, rmag_ff}, {1'b0, item_ff.magnitude}) > WIN_DB));

   assign hit =
      (rd_prof_ff == fprof_ff) &&
      (absdiff17({rd_ang_ff[31], rd_ang_ff[31:16]}, {item_ff.azimuth[15], item_ff.azimuth})
       <= TOL_POS) &&
      (absdiff17({rd_ang_ff[15], rd_ang_ff[15:0]}, {item_ff.elevation[15], item_ff.elevation})
       <= TOL_POS) &&
      (absdiff32(rd_dist_ff, item_ff.distance) <= 32'(TOL_POS)) &&
      (absdiff17({rd_sm_ff[31], rd_sm_ff[31:16]}, {item_ff.speed[15], item_ff.speed})
       <= TOL_POS) &&
      (absdiff17({1'b0, rd_sm_ff[15:0]}, {1'b0, item_ff.magnitude}) <= TOL_MAG);

   assign rd_en = cmd.search && (scan_ff < used_ff);

   assign stat.go       = (item_ff.command == CMD_TARGET) && fctl_ff[7] && !reject;
   assign stat.found    = pv_ff && hit;
   assign stat.miss     = !pv_ff && !(scan_ff < used_ff);
   assign stat.div_last = (step_ff == '0);

   assign ratio = (st_ff == ST_MATCHED) || (st_ff == ST_INSERTED);

   always_comb begin
      fprof_in = fprof_ff;
      fc_in    = fc_ff;
      used_in  = used_ff;
      scan_in  = scan_ff;
      pv_in    = pv_ff;
      pidx_in  = pidx_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      hits_in  = hits_ff;
      st_in    = st_ff;
      prod_in  = prod_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      sat_in   = sat_ff;
      wr_all   = 1'b0;
      wr_hit   = 1'b0;
      wr_addr  = idx_ff;
      if (cmd.exec) begin
         scan_in  = '0;
         pv_in    = 1'b0;
         found_in = 1'b0;
         idx_in   = '0;
         hits_in  = '0;
         st_in    = ST_IGNORED;
         case (item_ff.command)
            CMD_FRAME: begin
               if (!(item_ff.profile_code == 8'hFF && item_ff.object_count == 16'hFFFF)) begin
                  fprof_in = item_ff.profile_code;
                  fc_in    = sat_inc(fc_ff);
                  st_in    = ST_FRAME;
               end
            end
            CMD_CLEAR: begin
               used_in = '0;
               fc_in   = '0;
               st_in   = ST_CLEARED;
            end
            CMD_TARGET: begin
               if (fctl_ff[7] && reject) st_in = ST_FILTERED;
            end
            default: st_in = ST_IGNORED;
         endcase
      end
      if (cmd.search) begin
         pv_in   = rd_en;
         pidx_in = scan_ff[AW-1:0];
         if (rd_en) scan_in = scan_ff + 1'b1;
         if (pv_ff && hit && !found_ff) begin
            found_in = 1'b1;
            idx_in   = pidx_ff;
            hits_in  = sat_inc(rd_hits_ff);
         end
      end
      if (cmd.update) begin
         if (found_ff) begin
            wr_hit = 1'b1;
            st_in  = ST_MATCHED;
         end else if (used_ff < DEPTH_C) begin
            wr_all  = 1'b1;
            wr_addr = used_ff[AW-1:0];
            idx_in  = used_ff[AW-1:0];
            hits_in = 32'd1;
            used_in = used_ff + 1'b1;
            st_in   = ST_INSERTED;
         end else begin
            st_in = ST_FULL;
         end
      end
      if (cmd.mul) begin
         prod_in = {14'd0, hits_ff} * {32'd0, PERMYRIAD};
         sat_in  = (hits_ff >= fc_ff);
         dsh_in  = {1'b0, fc_ff, 13'd0};
         q_in    = '0;
         step_in = DIV_STEPS_M1;
      end
      if (cmd.div_step) begin
         if (prod_ff >= dsh_ff) prod_in = prod_ff - dsh_ff;
         q_in    = {q_ff[12:0], (prod_ff >= dsh_ff)};
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fctl_ff  <= '0;
         rdist_ff <= '0;
         razi_ff  <= '0;
         rele_ff  <= '0;
         rspd_ff  <= '0;
         rrcs_ff  <= '0;
         rsnr_ff  <= '0;
         rmag_ff  <= '0;
         fprof_ff <= '0;
         fc_ff    <= '0;
         used_ff  <= '0;
         scan_ff  <= '0;
         pv_ff    <= 1'b0;
         found_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FILTER_CONTROL: fctl_ff  <= csr_data[7:0];
               REG_REF_DISTANCE:   rdist_ff <= csr_data;
               REG_REF_AZIMUTH:    razi_ff  <= csr_data[15:0];
               REG_REF_ELEVATION:  rele_ff  <= csr_data[15:0];
               REG_REF_SPEED:      rspd_ff  <= csr_data[15:0];
               REG_REF_RCS:        rrcs_ff  <= csr_data[15:0];
               REG_REF_SNR:        rsnr_ff  <= csr_data[15:0];
               REG_REF_MAGNITUDE:  rmag_ff  <= csr_data[15:0];
               default: ;
            endcase
         end
         fprof_ff <= fprof_in;
         fc_ff    <= fc_in;
         used_ff  <= used_in;
         scan_ff  <= scan_in;
         pv_ff    <= pv_in;
         found_ff <= found_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= item;
      pidx_ff <= pidx_in;
      idx_ff  <= idx_in;
      hits_ff <= hits_in;
      st_ff   <= st_in;
      prod_ff <= prod_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      sat_ff  <= sat_in;
      if (cmd.out_load) begin
         rsp_status         <= st_ff;
         rsp_entry_index    <= 6'(idx_ff);
         rsp_hit_count      <= hits_ff;
         rsp_live_permyriad <= ratio ? (sat_ff ? PERMYRIAD : q_ff) : '0;
         rsp_frame_total    <= fc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_prof_ff <= prof_mem[scan_ff[AW-1:0]];
         rd_dist_ff <= dist_mem[scan_ff[AW-1:0]];
         rd_ang_ff  <= ang_mem[scan_ff[AW-1:0]];
         rd_sm_ff   <= sm_mem[scan_ff[AW-1:0]];
         rd_hits_ff <= hits_mem[scan_ff[AW-1:0]];
      end
      if (wr_all) begin
         prof_mem[wr_addr] <= fprof_ff;
         dist_mem[wr_addr] <= item_ff.distance;
         ang_mem[wr_addr]  <= {item_ff.azimuth, item_ff.elevation};
         sm_mem[wr_addr]   <= {item_ff.speed, item_ff.magnitude};
      end
      if (wr_all || wr_hit) begin
         rs_mem[wr_addr]   <= rs_word;
         hits_mem[wr_addr] <= wr_all ? 32'd1 : hits_ff;
      end
   end
endmodule

FILE: src/radar_target_tally_table_top.sv
// Top level of the radar target tally table
// A frame header, a clear or an ignored or filtered target passes from acceptance
// through the exec state to the result state, where its response is loaded. A
// tallied target scans the entry table one entry per cycle through the table's
// single read port and then runs a 14-step restoring divider for the live ratio.
// One transaction is in flight at a time; the next request is taken while the
// previous response still waits in its register.
module radar_target_tally_table_top #(
   parameter int TABLE_DEPTH = rttt_pkg::TABLE_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   rttt_req_if.sink    req_ch,
   rttt_rsp_if.source  rsp_ch,
   rttt_csr_if.sink    csr_ch
);
   import rttt_pkg::*;

   rttt_cmd_type  cmd;
   rttt_stat_type stat;
   rttt_item_type item;
   logic          req_ready;
   logic          rsp_valid;

   assign item.command      = req_ch.command;
   assign item.profile_code = req_ch.profile_code;
   assign item.object_count = req_ch.object_count;
   assign item.speed        = req_ch.speed;
   assign item.azimuth      = req_ch.azimuth;
   assign item.distance     = req_ch.distance;
   assign item.magnitude    = req_ch.magnitude;
   assign item.rcs          = req_ch.rcs;
   assign item.snr          = req_ch.snr;
   assign item.elevation    = req_ch.elevation;

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;
   assign csr_ch.ready = 1'b1;

   rttt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rttt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .item               (item),
      .csr_we             (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_status         (rsp_ch.status),
      .rsp_entry_index    (rsp_ch.entry_index),
      .rsp_hit_count      (rsp_ch.hit_count),
      .rsp_live_permyriad (rsp_ch.live_permyriad),
      .rsp_frame_total    (rsp_ch.frame_total)
   );
endmodule

FILE: src/rttt_checker.sv
// Port-level checker for the radar target tally table, bound to the top level
`include "radar_target_tally_table_top_defines.svh"

module rttt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_hit_count,
   input logic [13:0] rsp_live_permyriad,
   input logic [31:0] rsp_frame_total
);
   import rttt_pkg::*;

   logic tally_st;

   assign tally_st = (rsp_status == ST_MATCHED) || (rsp_status == ST_INSERTED);

   `RTTT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `RTTT_ASSERT_NOW(a_live_cap, rsp_valid, rsp_live_permyriad <= PERMYRIAD)
   `RTTT_ASSERT_NOW(a_tally_nonzero, rsp_valid && tally_st, rsp_hit_count != 32'd0)
   `RTTT_ASSERT_NOW(a_clear_zero, rsp_valid && rsp_status == ST_CLEARED, rsp_frame_total == 32'd0)
endmodule

bind radar_target_tally_table_top rttt_checker u_rttt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_hit_count      (rsp_ch.hit_count),
   .rsp_live_permyriad (rsp_ch.live_permyriad),
   .rsp_frame_total    (rsp_ch.frame_total)
);

FILE: verif/radar_target_tally_table_checker.sv
// Checker for the radar target tally table: watches channels, predicts and compares
module radar_target_tally_table_checker #(
   parameter int DEPTH = rttt_pkg::TABLE_DEPTH_DEF
) (
   input  logic  clock,
   input  logic  reset,
   rttt_req_if   req_ch,
   rttt_rsp_if   rsp_ch,
   rttt_csr_if   csr_ch,
   output int    fail_count,
   output int    pending
);
   import rttt_pkg::*;

   typedef struct {
      logic [2:0]  status;
      logic [5:0]  entry_index;
      logic [31:0] hit_count;
      logic [13:0] live_permyriad;
      logic [31:0] frame_total;
   } tally_result_t;

   tally_result_t expected_results[$];

   logic [7:0]         ctl;
   logic [31:0]        ref_dist;
   logic signed [15:0] ref_azi, ref_ele, ref_spd, ref_rcs, ref_snr;
   logic [15:0]        ref_mag;

   logic [7:0]  cur_profile;
   logic [31:0] frame_count;
   int          used;
   logic [7:0]         t_prof[DEPTH];
   logic [31:0]        t_dist[DEPTH];
   logic signed [15:0] t_azi[DEPTH], t_ele[DEPTH], t_spd[DEPTH];
   logic [15:0]        t_mag[DEPTH];
   logic [31:0]        t_hits[DEPTH];

   function automatic longint gap(longint a, longint b);
      return a > b ? a - b : b - a;
   endfunction

   function automatic bit win_out(int b, longint a, longint v, longint w);
      return ctl[b] && gap(a, v) > w;
   endfunction

   function automatic logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [13:0] ratio(logic [31:0] h);
      longint q;
      if (frame_count == 0) return 14'd10000;
      q = (longint'({32'b0, h}) * 10000) / longint'({32'b0, frame_count});
      return (q > 10000) ? 14'd10000 : 14'(q);
   endfunction

   function automatic tally_result_t predict_tally(rttt_item_type it);
      tally_result_t r;
      int hit;
      r = '{default: '0};
      hit = -1;
      case (it.command)
         CMD_FRAME: begin
            if (!(it.profile_code == 8'hFF && it.object_count == 16'hFFFF)) begin
               cur_profile = it.profile_code;
               frame_count = bump(frame_count);
               r.status = ST_FRAME;
            end else begin
               r.status = ST_IGNORED;
            end
         end
         CMD_CLEAR: begin
            used = 0;
            frame_count = 0;
            r.status = ST_CLEARED;
         end
         CMD_TARGET: begin
            if (!ctl[7]) begin
               r.status = ST_IGNORED;
            end else if (win_out(0, longint'(ref_dist), longint'(it.distance), 200) ||
                         win_out(1, ref_azi, it.azimuth, 500) ||
                         win_out(2, ref_ele, it.elevation, 500) ||
                         win_out(3, ref_spd, it.speed, 200) ||
                         win_out(4, ref_rcs, it.rcs, 50) ||
                         win_out(5, ref_snr, it.snr, 50) ||
                         win_out(6, longint'(ref_mag), longint'(it.magnitude), 50)) begin
               r.status = ST_FILTERED;
            end else begin
               for (int i = 0; i < used; i++) begin
                  if (t_prof[i] == cur_profile && gap(t_azi[i], it.azimuth) <= 5 &&
                      gap(t_ele[i], it.elevation) <= 5 &&
                      gap(longint'(t_dist[i]), longint'(it.distance)) <= 5 &&
                      gap(t_spd[i], it.speed) <= 5 &&
                      gap(longint'(t_mag[i]), longint'(it.magnitude)) <= 30) begin
                     hit = i;
                     break;
                  end
               end
               if (hit >= 0) begin
                  t_hits[hit] = bump(t_hits[hit]);
                  r.status = ST_MATCHED;
                  r.entry_index = 6'(hit);
                  r.hit_count = t_hits[hit];
                  r.live_permyriad = ratio(t_hits[hit]);
               end else if (used < DEPTH) begin
                  t_prof[used] = cur_profile;
                  t_dist[used] = it.distance;
                  t_azi[used] = it.azimuth;
                  t_ele[used] = it.elevation;
                  t_spd[used] = it.speed;
                  t_mag[used] = it.magnitude;
                  t_hits[used] = 32'd1;
                  r.status = ST_INSERTED;
                  r.entry_index = 6'(used);
                  r.hit_count = 32'd1;
                  r.live_permyriad = ratio(32'd1);
                  used++;
               end else begin
                  r.status = ST_FULL;
               end
            end
         end
         default: r.status = ST_IGNORED;
      endcase
      r.frame_total = frame_count;
      return r;
   endfunction

   function automatic void check_field(string name, longint e, longint a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
         fail_count++;
      end
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      rttt_item_type it;
      tally_result_t e;
      if (reset) begin
         ctl = 0; ref_dist = 0; ref_azi = 0; ref_ele = 0; ref_spd = 0;
         ref_rcs = 0; ref_snr = 0; ref_mag = 0;
         cur_profile = 0; frame_count = 0; used = 0;
         fail_count = 0;
         expected_results.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_FILTER_CONTROL: ctl = csr_ch.data[7:0];
               REG_REF_DISTANCE:   ref_dist = csr_ch.data;
               REG_REF_AZIMUTH:    ref_azi = csr_ch.data[15:0];
               REG_REF_ELEVATION:  ref_ele = csr_ch.data[15:0];
               REG_REF_SPEED:      ref_spd = csr_ch.data[15:0];
               REG_REF_RCS:        ref_rcs = csr_ch.data[15:0];
               REG_REF_SNR:        ref_snr = csr_ch.data[15:0];
               REG_REF_MAGNITUDE:  ref_mag = csr_ch.data[15:0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, status %0d", $time, rsp_ch.status);
               fail_count++;
            end else begin
               e = expected_results.pop_front();
               check_field("status", e.status, rsp_ch.status);
               check_field("entry_index", e.entry_index, rsp_ch.entry_index);
               check_field("hit_count", e.hit_count, rsp_ch.hit_count);
               check_field("live_permyriad", e.live_permyriad, rsp_ch.live_permyriad);
               check_field("frame_total", e.frame_total, rsp_ch.frame_total);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            it.command = req_ch.command;
            it.profile_code = req_ch.profile_code;
            it.object_count = req_ch.object_count;
            it.speed = req_ch.speed;
            it.azimuth = req_ch.azimuth;
            it.distance = req_ch.distance;
            it.magnitude = req_ch.magnitude;
            it.rcs = req_ch.rcs;
            it.snr = req_ch.snr;
            it.elevation = req_ch.elevation;
            expected_results.push_back(predict_tally(it));
         end
      end
   end
endmodule

FILE: verif/radar_target_tally_table_top_test.sv
// Testbench top for the radar target tally table: stimulus, idling, watchdog and verdict
module radar_target_tally_table_top_test;
   import rttt_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   items_sent;
   int   idle_cycles;
   bit   no_idle;
   bit   hold_rsp;

   rttt_req_if req_ch ();
   rttt_rsp_if rsp_ch ();
   rttt_csr_if csr_ch ();

   radar_target_tally_table_top dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   radar_target_tally_table_checker checker_inst (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   rttt_item_type pool[$];

   function automatic rttt_item_type tgt(logic [31:0] d, logic [15:0] s, logic [15:0] a,
                                         logic [15:0] e, logic [15:0] m, logic [15:0] r,
                                         logic [15:0] n);
      rttt_item_type it;
      it = '0;
      it.command = CMD_TARGET;
      it.distance = d; it.speed = s; it.azimuth = a; it.elevation = e;
      it.magnitude = m; it.rcs = r; it.snr = n;
      return it;
   endfunction

   function automatic rttt_item_type frame(logic [7:0] p, logic [15:0] c);
      rttt_item_type it;
      it = '0;
      it.command = CMD_FRAME;
      it.profile_code = p;
      it.object_count = c;
      return it;
   endfunction

   function automatic rttt_item_type noise();
      rttt_item_type it;
      it.command = 2'($urandom_range(3));
      it.profile_code = 8'($urandom);
      it.object_count = 16'($urandom);
      it.speed = 16'($urandom); it.azimuth = 16'($urandom);
      it.distance = $urandom; it.magnitude = 16'($urandom);
      it.rcs = 16'($urandom); it.snr = 16'($urandom); it.elevation = 16'($urandom);
      return it;
   endfunction

   function automatic rttt_item_type jitter(rttt_item_type b);
      rttt_item_type it;
      it = b;
      it.distance = b.distance + 32'($signed($urandom_range(14)) - 7);
      it.speed = b.speed + 16'($signed($urandom_range(14)) - 7);
      it.azimuth = b.azimuth + 16'($signed($urandom_range(14)) - 7);
      it.elevation = b.elevation + 16'($signed($urandom_range(14)) - 7);
      it.magnitude = b.magnitude + 16'($signed($urandom_range(70)) - 35);
      it.rcs = 16'($urandom); it.snr = 16'($urandom);
      return it;
   endfunction

   task automatic send_item(rttt_item_type it);
      if (!no_idle && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= it.command;
      req_ch.profile_code <= it.profile_code;
      req_ch.object_count <= it.object_count;
      req_ch.speed <= it.speed;
      req_ch.azimuth <= it.azimuth;
      req_ch.distance <= it.distance;
      req_ch.magnitude <= it.magnitude;
      req_ch.rcs <= it.rcs;
      req_ch.snr <= it.snr;
      req_ch.elevation <= it.elevation;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_refs(rttt_item_type b);
      write_reg(REG_REF_DISTANCE, b.distance);
      write_reg(REG_REF_AZIMUTH, {16'b0, b.azimuth});
      write_reg(REG_REF_ELEVATION, {16'b0, b.elevation});
      write_reg(REG_REF_SPEED, {16'b0, b.speed});
      write_reg(REG_REF_RCS, {16'b0, b.rcs});
      write_reg(REG_REF_SNR, {16'b0, b.snr});
      write_reg(REG_REF_MAGNITUDE, {16'b0, b.magnitude});
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end else begin
            rsp_ch.ready <= no_idle || $urandom_range(99) >= 16;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      rttt_item_type base, it;
      int kind, n;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= '0; req_ch.profile_code <= '0; req_ch.object_count <= '0;
      req_ch.speed <= '0; req_ch.azimuth <= '0; req_ch.distance <= '0;
      req_ch.magnitude <= '0; req_ch.rcs <= '0; req_ch.snr <= '0; req_ch.elevation <= '0;
      csr_ch.valid <= 1'b0; csr_ch.index <= '0; csr_ch.data <= '0;
      items_sent = 0; no_idle = 0; hold_rsp = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(tgt(32'd100, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6));
      it = noise(); it.command = 2'd3;
      send_item(it);
      send_item(frame(8'hFF, 16'hFFFF));
      it = '0; it.command = CMD_CLEAR;
      send_item(it);
      wait_drained();
      write_reg(REG_FILTER_CONTROL, 32'h80);
      send_item(tgt(32'd500, 16'd0, 16'd0, 16'd0, 16'd100, 16'd0, 16'd0));
      send_item(frame(8'hFF, 16'h0000));
      send_item(frame(8'h00, 16'hFFFF));
      send_item(tgt(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000,
                    16'h7FFF));
      send_item(tgt(32'hFFFF_FFFA, 16'h7FFA, 16'h8005, 16'h7FFA, 16'hFFFF, 16'h7FFF,
                    16'h8000));
      send_item(tgt(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFE1, 16'h0, 16'h0));
      send_item(tgt(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFE0, 16'h0, 16'h0));
      send_item(tgt(32'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'h0, 16'hFFFF));
      send_item(tgt(32'd0, 16'h8000, 16'h7FF9, 16'h8000, 16'd0, 16'h0, 16'h0));
      wait_drained();
      write_reg(REG_FILTER_CONTROL, 32'hFF);
      base = tgt(32'd1000, 16'd0, 16'h8000, 16'h7FFF, 16'hFFFF, -16'sd100, 16'd100);
      write_refs(base);
      send_item(base);
      it = base; it.distance = 32'd1201; send_item(it);
      it = base; it.distance = 32'd1200; send_item(it);
      it = base; it.azimuth = 16'h8000 + 16'd501; send_item(it);
      it = base; it.magnitude = 16'd65485; send_item(it);
      it = base; it.snr = 16'd49; send_item(it);
      it = base; it.speed = 16'd201; send_item(it);
      it = '0; it.command = CMD_CLEAR;
      send_item(it);
      wait_drained();

      for (int ph = 0; items_sent < 380; ph++) begin
         wait_drained();
         pool.delete();
         n = (ph % 4 == 2) ? 72 : $urandom_range(4, 24);
         for (int i = 0; i < n; i++) begin
            base = noise();
            base.command = CMD_TARGET;
            if ($urandom_range(1)) base.distance = $urandom_range(20000);
            pool.push_back(base);
         end
         no_idle = (ph % 4 == 0);
         if (ph % 4 == 2) begin
            write_reg(REG_FILTER_CONTROL, 32'h80);
            it = '0; it.command = CMD_CLEAR;
            send_item(it);
            send_item(frame(8'd1, 16'd3));
            foreach (pool[i]) send_item(pool[i]);
            continue;
         end
         write_reg(REG_FILTER_CONTROL,
                   {24'd0, $urandom_range(9) != 0, 7'($urandom & $urandom & $urandom)});
         base = pool[0];
         if ($urandom_range(3) == 0) begin
            base.distance = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            base.speed = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            base.magnitude = $urandom_range(1) ? 16'hFFFF : 16'h0;
         end
         write_refs(base);
         if (ph % 4 == 1) hold_rsp = 1;
         for (int k = 0; k < 40; k++) begin
            kind = $urandom_range(99);
            if (kind < 12) begin
               it = frame(8'($urandom_range(3)), 16'($urandom));
               if ($urandom_range(7) == 0) it = frame(8'hFF, 16'hFFFF);
            end else if (kind < 15) begin
               it = '0; it.command = CMD_CLEAR;
            end else if (kind < 23) begin
               it = noise();
            end else begin
               it = jitter(pool[$urandom_range(pool.size() - 1)]);
            end
            send_item(it);
         end
      end

      no_idle = 0;
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+src
src/rttt_pkg.sv
src/rttt_if.sv
src/rttt_ctrl.sv
src/rttt_dp.sv
src/radar_target_tally_table_top.sv
src/rttt_checker.sv
verif/radar_target_tally_table_checker.sv
verif/radar_target_tally_table_top_test.sv
